>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, masked while reset is high
`define FCSV_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// concurrent assertion that is also checked during reset
`define FCSV_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

>>> rtl/fcsv_pkg.sv
// package with widths, reset values and register codes of the framed csv parser
`default_nettype none

package fcsv_pkg;

   localparam int VALUE_BITS     = 32;
   localparam int OUT_BITS       = 32;
   localparam int BYTE_BITS      = 8;
   localparam int LIMIT_BITS     = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [BYTE_BITS-1:0]  HEADER_RESET    = 8'h40;
   localparam logic [BYTE_BITS-1:0]  TAIL_RESET      = 8'h3f;
   localparam logic [BYTE_BITS-1:0]  SEPARATOR_RESET = 8'h2c;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET     = 16'd100;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_HEADER     = 2'd0,
      CSR_TAIL       = 2'd1,
      CSR_SEPARATOR  = 2'd2,
      CSR_JUMP_LIMIT = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

>>> rtl/fcsv_req_if.sv
// byte channel into the parser
`default_nettype none

interface fcsv_req_if;
   logic                           valid;
   logic                           ready;
   logic [fcsv_pkg::BYTE_BITS-1:0] rx_byte;
   logic                           buffer_end;

   modport source (output valid, output rx_byte, output buffer_end, input ready);
   modport sink (input valid, input rx_byte, input buffer_end, output ready);
endinterface

`default_nettype wire

>>> rtl/fcsv_rsp_if.sv
// result channel out of the parser
`default_nettype none

interface fcsv_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [fcsv_pkg::OUT_BITS-1:0] value_first;
   logic signed [fcsv_pkg::OUT_BITS-1:0] value_second;
   logic signed [fcsv_pkg::OUT_BITS-1:0] value_third;
   logic                                 plausible;

   modport source (output valid, output value_first, output value_second,
                   output value_third, output plausible, input ready);
   modport sink (input valid, input value_first, input value_second,
                 input value_third, input plausible, output ready);
endinterface

`default_nettype wire

>>> rtl/framed_csv_triple_parser_unit.sv
// top level of the framed csv triple parser
//
//   channel   direction  transaction
//   req_bus   in         one received byte with its buffer end mark
//   rsp_bus   out        three parsed values and the plausibility flag
//   csr_*     in         register write, one per cycle, no wait
//
// one byte per cycle sustained unless a closing byte stalls; a byte is held in the input register
// and its result, if any, is then registered in the output register
// the parse state and the output register are updated in the same cycle
// a waiting result stalls only a closing byte, other bytes keep flowing
// synchronous active high reset restores the csr registers and parse state, clears the valid flags and the history
`default_nettype none

module framed_csv_triple_parser_unit (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   fcsv_req_if.sink                                     req_bus,
   fcsv_rsp_if.source                                   rsp_bus,
   input  wire logic                                    csr_write_enable,
   input  wire logic [fcsv_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [fcsv_pkg::CSR_DATA_BITS-1:0]      csr_write_data
);

   localparam int VB    = fcsv_pkg::VALUE_BITS;
   localparam int EXT_W = VB + 4;
   localparam int CMP_W = (VB + 1 > fcsv_pkg::LIMIT_BITS) ? VB + 1 : fcsv_pkg::LIMIT_BITS;
   localparam logic [VB-1:0] MAG_TOP = {1'b1, {(VB-1){1'b0}}};
   localparam logic [VB-1:0] POS_MAX = {1'b0, {(VB-1){1'b1}}};

   typedef enum logic [1:0] {
      PH_SKIP   = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   logic [fcsv_pkg::BYTE_BITS-1:0]  header_ff, tail_ff, separator_ff;
   logic [fcsv_pkg::LIMIT_BITS-1:0] limit_ff;

   logic                           s1_valid_ff;
   logic [fcsv_pkg::BYTE_BITS-1:0] s1_byte_ff;
   logic                           s1_end_ff;

   logic                 in_frame_ff, in_frame_in;
   logic [1:0]           field_ff, field_in;
   phase_type            phase_ff, phase_in;
   logic                 negative_ff, negative_in;
   logic [VB-1:0]        mag_ff, mag_in;
   logic                 content_ff, content_in;
   logic signed [VB-1:0] held_first_ff, held_first_in;
   logic signed [VB-1:0] held_second_ff, held_second_in;
   logic signed [VB-1:0] prev_ff [3];
   logic signed [VB-1:0] prev_in [3];

   logic                               out_valid_ff;
   logic signed [fcsv_pkg::OUT_BITS-1:0] out_first_ff, out_second_ff, out_third_ff;
   logic                               out_plausible_ff;

   logic                 emit;
   logic                 advance;
   logic                 digit, space;
   logic [EXT_W-1:0]     mag_sum;
   logic signed [VB-1:0] cur_state;
   logic signed [VB-1:0] cur_fed;
   logic signed [VB-1:0] vals [3];
   logic signed [VB:0]   diff [3];
   logic [VB:0]          diff_abs [3];
   logic                 ok;

   function automatic logic signed [VB-1:0] current_value(input logic neg,
                                                          input logic [VB-1:0] mag);
      logic signed [VB-1:0] r;
      if (neg) begin
         r = signed'(~mag + 1'b1);
      end else if (mag >= MAG_TOP) begin
         r = signed'(POS_MAX);
      end else begin
         r = signed'(mag);
      end
      return r;
   endfunction

   always_comb begin
      digit = (s1_byte_ff >= 8'h30) && (s1_byte_ff <= 8'h39);
      space = (s1_byte_ff == 8'h20) || ((s1_byte_ff >= 8'h09) && (s1_byte_ff <= 8'h0d));
      cur_state = current_value(negative_ff, mag_ff);

      vals[0] = (field_ff == 2'd0) ? cur_state : held_first_ff;
      vals[1] = (field_ff == 2'd1) ? cur_state :
                ((field_ff >= 2'd2) ? held_second_ff : '0);
      vals[2] = (field_ff >= 2'd2) ? cur_state : '0;
      ok = 1'b1;
      for (int k = 0; k < 3; k++) begin
         diff[k] = {vals[k][VB-1], vals[k]} - {prev_ff[k][VB-1], prev_ff[k]};
         diff_abs[k] = diff[k][VB] ? (~diff[k] + 1'b1) : diff[k];
         if (CMP_W'(diff_abs[k]) >= CMP_W'(limit_ff)) begin
            ok = 1'b0;
         end
      end

      in_frame_in    = in_frame_ff;
      field_in       = field_ff;
      phase_in       = phase_ff;
      negative_in    = negative_ff;
      mag_in         = mag_ff;
      content_in     = content_ff;
      held_first_in  = held_first_ff;
      held_second_in = held_second_ff;
      for (int k = 0; k < 3; k++) begin
         prev_in[k] = prev_ff[k];
      end
      emit    = 1'b0;
      mag_sum = '0;
      cur_fed = '0;

      if (!in_frame_ff) begin
         if (s1_byte_ff == header_ff) begin
            in_frame_in    = 1'b1;
            field_in       = 2'd0;
            content_in     = 1'b0;
            held_first_in  = '0;
            held_second_in = '0;
            phase_in       = PH_SKIP;
            negative_in    = 1'b0;
            mag_in         = '0;
         end
      end else if (s1_byte_ff == tail_ff) begin
         in_frame_in = 1'b0;
         emit        = content_ff;
         if (content_ff) begin
            for (int k = 0; k < 3; k++) begin
               prev_in[k] = vals[k];
            end
         end
         phase_in    = PH_SKIP;
         negative_in = 1'b0;
         mag_in      = '0;
         field_in    = 2'd0;
         content_in  = 1'b0;
      end else begin
         content_in = 1'b1;
         case (phase_ff)
            PH_SKIP: begin
               if (space) begin
                  phase_in = PH_SKIP;
               end else if ((s1_byte_ff == 8'h2b) || (s1_byte_ff == 8'h2d)) begin
                  negative_in = (s1_byte_ff == 8'h2d);
                  phase_in    = PH_SIGN;
               end else if (digit) begin
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_DONE;
               end
            end
            PH_SIGN: begin
               phase_in = digit ? PH_DIGITS : PH_DONE;
            end
            PH_DIGITS: begin
               if (!digit) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
         if (digit && (phase_in == PH_DIGITS)) begin
            mag_sum = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1)
                    + EXT_W'(s1_byte_ff[3:0]);
            mag_in  = (mag_sum > EXT_W'(MAG_TOP)) ? MAG_TOP : mag_sum[VB-1:0];
         end
         cur_fed = current_value(negative_in, mag_in);
         if ((s1_byte_ff == separator_ff) && (field_ff < 2'd2)) begin
            if (field_ff == 2'd0) begin
               held_first_in = cur_fed;
            end else begin
               held_second_in = cur_fed;
            end
            field_in    = field_ff + 2'd1;
            phase_in    = PH_SKIP;
            negative_in = 1'b0;
            mag_in      = '0;
         end
      end

      if (s1_end_ff && in_frame_in) begin
         in_frame_in = 1'b0;
         field_in    = 2'd0;
         content_in  = 1'b0;
         phase_in    = PH_SKIP;
         negative_in = 1'b0;
         mag_in      = '0;
      end
   end

   assign advance = s1_valid_ff && (!emit || !out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.value_first  = out_first_ff;
   assign rsp_bus.value_second = out_second_ff;
   assign rsp_bus.value_third  = out_third_ff;
   assign rsp_bus.plausible    = out_plausible_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff      <= fcsv_pkg::HEADER_RESET;
         tail_ff        <= fcsv_pkg::TAIL_RESET;
         separator_ff   <= fcsv_pkg::SEPARATOR_RESET;
         limit_ff       <= fcsv_pkg::LIMIT_RESET;
         s1_valid_ff    <= 1'b0;
         in_frame_ff    <= 1'b0;
         field_ff       <= 2'd0;
         phase_ff       <= PH_SKIP;
         negative_ff    <= 1'b0;
         mag_ff         <= '0;
         content_ff     <= 1'b0;
         held_first_ff  <= '0;
         held_second_ff <= '0;
         for (int k = 0; k < 3; k++) begin
            prev_ff[k] <= '0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (fcsv_pkg::csr_index_type'(csr_index))
               fcsv_pkg::CSR_HEADER:     header_ff    <= csr_write_data[7:0];
               fcsv_pkg::CSR_TAIL:       tail_ff      <= csr_write_data[7:0];
               fcsv_pkg::CSR_SEPARATOR:  separator_ff <= csr_write_data[7:0];
               fcsv_pkg::CSR_JUMP_LIMIT: limit_ff     <= csr_write_data;
               default: begin
               end
            endcase
         end

         if (req_bus.valid && req_bus.ready) begin
            s1_valid_ff <= 1'b1;
            s1_byte_ff  <= req_bus.rx_byte;
            s1_end_ff   <= req_bus.buffer_end;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end

         if (advance) begin
            in_frame_ff    <= in_frame_in;
            field_ff       <= field_in;
            phase_ff       <= phase_in;
            negative_ff    <= negative_in;
            mag_ff         <= mag_in;
            content_ff     <= content_in;
            held_first_ff  <= held_first_in;
            held_second_ff <= held_second_in;
            for (int k = 0; k < 3; k++) begin
               prev_ff[k] <= prev_in[k];
            end
         end

         if (advance && emit) begin
            out_valid_ff     <= 1'b1;
            out_first_ff     <= fcsv_pkg::OUT_BITS'(vals[0]);
            out_second_ff    <= fcsv_pkg::OUT_BITS'(vals[1]);
            out_third_ff     <= fcsv_pkg::OUT_BITS'(vals[2]);
            out_plausible_ff <= ok;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/fcsv_checker.sv
// port level assertions of the framed csv parser and their bind
`default_nettype none

`include "assert_macros.svh"

module fcsv_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_ready,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic signed [fcsv_pkg::OUT_BITS-1:0] rsp_value_first,
   input wire logic signed [fcsv_pkg::OUT_BITS-1:0] rsp_value_second,
   input wire logic signed [fcsv_pkg::OUT_BITS-1:0] rsp_value_third,
   input wire logic                                 rsp_plausible
);

   // a stalled result holds
   `FCSV_ASSERT(a_rsp_hold, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value_first)
         && $stable(rsp_value_second) && $stable(rsp_value_third)
         && $stable(rsp_plausible)))

   // reset empties the output register
   `FCSV_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid)

   // a fresh result follows an accepted byte
   `FCSV_ASSERT(a_rsp_latency, clock, reset,
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))

endmodule

bind framed_csv_triple_parser_unit fcsv_checker u_fcsv_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_value_first  (rsp_bus.value_first),
   .rsp_value_second (rsp_bus.value_second),
   .rsp_value_third  (rsp_bus.value_third),
   .rsp_plausible    (rsp_bus.plausible)
);

`default_nettype wire

>>> bench/tb_top.sv
// self-checking testbench for the framed csv triple parser unit
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEMS_TOTAL     = 2000;
   localparam int PHASE_COUNT     = 7;
   localparam int ITEMS_PER_PHASE = ITEMS_TOTAL / PHASE_COUNT;
   localparam int QUIET_CYCLES    = 6;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [fcsv_pkg::BYTE_BITS-1:0] CHAR_TAB   = 8'h09;
   localparam logic [fcsv_pkg::BYTE_BITS-1:0] CHAR_CR    = 8'h0d;
   localparam logic [fcsv_pkg::BYTE_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [fcsv_pkg::BYTE_BITS-1:0] CHAR_PLUS  = 8'h2b;
   localparam logic [fcsv_pkg::BYTE_BITS-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [fcsv_pkg::BYTE_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [fcsv_pkg::BYTE_BITS-1:0] CHAR_NINE  = 8'h39;

   localparam longint unsigned SAT_MAGNITUDE = 64'd1 << (fcsv_pkg::VALUE_BITS - 1);
   localparam longint VALUE_MAX = 64'sd2147483647;
   localparam longint VALUE_MIN = -64'sd2147483648;

   typedef enum int {SKIP_SPACE, AFTER_SIGN, IN_DIGITS, NUMBER_DONE} number_state_type;

   typedef struct {
      logic signed [fcsv_pkg::OUT_BITS-1:0] first;
      logic signed [fcsv_pkg::OUT_BITS-1:0] second;
      logic signed [fcsv_pkg::OUT_BITS-1:0] third;
      logic                                 plausible;
   } triple_type;

   typedef struct {
      logic [fcsv_pkg::BYTE_BITS-1:0] value;
      logic                           last_of_buffer;
   } rx_item_type;

   class triple_scoreboard_type;
      logic [fcsv_pkg::BYTE_BITS-1:0]  header_code;
      logic [fcsv_pkg::BYTE_BITS-1:0]  tail_code;
      logic [fcsv_pkg::BYTE_BITS-1:0]  separator_code;
      logic [fcsv_pkg::LIMIT_BITS-1:0] jump_limit;
      bit                    in_frame;
      bit                    negative;
      bit                    content_seen;
      int                    field_index;
      number_state_type      number_state;
      longint unsigned       magnitude;
      longint                held_first;
      longint                held_second;
      longint                previous_triple[3];
      triple_type            expected_triples[$];
      int                    error_count;
      int                    reports;
      int                    checked_count;
      int                    plausible_count;
      int                    saturated_count;

      function new();
         header_code     = fcsv_pkg::HEADER_RESET;
         tail_code       = fcsv_pkg::TAIL_RESET;
         separator_code  = fcsv_pkg::SEPARATOR_RESET;
         jump_limit      = fcsv_pkg::LIMIT_RESET;
         in_frame        = 1'b0;
         content_seen    = 1'b0;
         field_index     = 0;
         held_first      = 0;
         held_second     = 0;
         previous_triple = '{0, 0, 0};
         error_count     = 0;
         reports         = 0;
         checked_count   = 0;
         plausible_count = 0;
         saturated_count = 0;
         clear_number();
      endfunction

      function void set_register(fcsv_pkg::csr_index_type idx,
                                 logic [fcsv_pkg::CSR_DATA_BITS-1:0] data);
         case (idx)
            fcsv_pkg::CSR_HEADER:     header_code    = data[fcsv_pkg::BYTE_BITS-1:0];
            fcsv_pkg::CSR_TAIL:       tail_code      = data[fcsv_pkg::BYTE_BITS-1:0];
            fcsv_pkg::CSR_SEPARATOR:  separator_code = data[fcsv_pkg::BYTE_BITS-1:0];
            fcsv_pkg::CSR_JUMP_LIMIT: jump_limit     = data[fcsv_pkg::LIMIT_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void clear_number();
         number_state = SKIP_SPACE;
         negative     = 1'b0;
         magnitude    = 0;
      endfunction

      function longint current_value();
         if (negative) return -longint'(magnitude);
         if (magnitude >= SAT_MAGNITUDE) return longint'(SAT_MAGNITUDE) - 1;
         return longint'(magnitude);
      endfunction

      function void step_number(logic [fcsv_pkg::BYTE_BITS-1:0] b);
         bit is_digit;
         bit is_space;
         is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
         is_space = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
         case (number_state)
            SKIP_SPACE: begin
               if (!is_space) begin
                  if (b == CHAR_PLUS || b == CHAR_MINUS) begin
                     negative     = (b == CHAR_MINUS);
                     number_state = AFTER_SIGN;
                  end else begin
                     number_state = is_digit ? IN_DIGITS : NUMBER_DONE;
                  end
               end
            end
            AFTER_SIGN: number_state = is_digit ? IN_DIGITS : NUMBER_DONE;
            IN_DIGITS: begin
               if (!is_digit) number_state = NUMBER_DONE;
            end
            default: number_state = NUMBER_DONE;
         endcase
         if (is_digit && number_state == IN_DIGITS) begin
            magnitude = magnitude * 10 + 64'(b - CHAR_ZERO);
            if (magnitude > SAT_MAGNITUDE) magnitude = SAT_MAGNITUDE;
         end
      endfunction

      function void close_frame();
         longint     vals[3];
         longint     cur;
         longint     delta;
         triple_type want;
         cur     = current_value();
         vals[0] = (field_index == 0) ? cur : held_first;
         vals[1] = (field_index == 1) ? cur : ((field_index >= 2) ? held_second : 0);
         vals[2] = (field_index >= 2) ? cur : 0;
         want.plausible = 1'b1;
         for (int k = 0; k < 3; k++) begin
            delta = vals[k] - previous_triple[k];
            if (delta < 0) delta = -delta;
            if (delta >= longint'(jump_limit)) want.plausible = 1'b0;
            if (vals[k] == VALUE_MAX || vals[k] == VALUE_MIN) saturated_count++;
            previous_triple[k] = vals[k];
         end
         want.first  = vals[0][fcsv_pkg::OUT_BITS-1:0];
         want.second = vals[1][fcsv_pkg::OUT_BITS-1:0];
         want.third  = vals[2][fcsv_pkg::OUT_BITS-1:0];
         expected_triples.push_back(want);
      endfunction

      function void absorb_byte(logic [fcsv_pkg::BYTE_BITS-1:0] b, logic last_of_buffer);
         if (!in_frame) begin
            if (b == header_code) begin
               in_frame     = 1'b1;
               field_index  = 0;
               content_seen = 1'b0;
               held_first   = 0;
               held_second  = 0;
               clear_number();
            end
         end else if (b == tail_code) begin
            in_frame = 1'b0;
            if (content_seen) close_frame();
            clear_number();
            field_index  = 0;
            content_seen = 1'b0;
         end else begin
            content_seen = 1'b1;
            step_number(b);
            if (b == separator_code && field_index < 2) begin
               if (field_index == 0) held_first = current_value();
               else held_second = current_value();
               field_index++;
               clear_number();
            end
         end
         if (last_of_buffer && in_frame) begin
            in_frame     = 1'b0;
            field_index  = 0;
            content_seen = 1'b0;
            clear_number();
         end
      endfunction

      function int pending();
         return expected_triples.size();
      endfunction

      function void note_mismatch(string name, logic signed [fcsv_pkg::OUT_BITS-1:0] want,
                                  logic signed [fcsv_pkg::OUT_BITS-1:0] got);
         error_count++;
         if (reports < REPORT_LIMIT) begin
            reports++;
            $display("tb_top: mismatch in %s of result %0d: expected %0d, got %0d",
                     name, checked_count, want, got);
         end
      endfunction

      function void check_triple(triple_type got);
         triple_type want;
         if (expected_triples.size() == 0) begin
            error_count++;
            if (reports < REPORT_LIMIT) begin
               reports++;
               $display("tb_top: result %0d %0d %0d plausible %0b with none expected",
                        got.first, got.second, got.third, got.plausible);
            end
            return;
         end
         want = expected_triples.pop_front();
         checked_count++;
         if (want.plausible) plausible_count++;
         if (got.first !== want.first) note_mismatch("value_first", want.first, got.first);
         if (got.second !== want.second)
            note_mismatch("value_second", want.second, got.second);
         if (got.third !== want.third) note_mismatch("value_third", want.third, got.third);
         if (got.plausible !== want.plausible)
            note_mismatch("plausible", 32'(want.plausible), 32'(got.plausible));
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                csr_write_enable;
   logic [fcsv_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [fcsv_pkg::CSR_DATA_BITS-1:0]  csr_write_data;

   fcsv_req_if req_bus();
   fcsv_rsp_if rsp_bus();

   framed_csv_triple_parser_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   triple_scoreboard_type sb = new();
   rx_item_type      frame_bytes[$];
   int               bytes_sent = 0;
   int               settings_applied = 0;
   int               hold_count = 0;
   int               hold_requests = 0;
   int               quiet_cycles = 0;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 70);
   endfunction

   function automatic void push_byte(logic [fcsv_pkg::BYTE_BITS-1:0] value,
                                     logic last_of_buffer);
      rx_item_type it;
      it.value          = value;
      it.last_of_buffer = last_of_buffer;
      frame_bytes.push_back(it);
   endfunction

   function automatic void push_text(string s, bit end_last);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], end_last && (i == s.len() - 1));
   endfunction

   function automatic logic [fcsv_pkg::BYTE_BITS-1:0] junk_byte();
      logic [fcsv_pkg::BYTE_BITS-1:0] b;
      do b = fcsv_pkg::BYTE_BITS'($urandom_range(0, 255)); while (b == sb.tail_code);
      return b;
   endfunction

   function automatic logic [fcsv_pkg::BYTE_BITS-1:0] outside_byte();
      logic [fcsv_pkg::BYTE_BITS-1:0] b;
      do b = fcsv_pkg::BYTE_BITS'($urandom_range(0, 255)); while (b == sb.header_code);
      return b;
   endfunction

   function automatic logic [fcsv_pkg::BYTE_BITS-1:0] space_byte();
      int k;
      k = $urandom_range(0, 5);
      return (k == 5) ? CHAR_SPACE : CHAR_TAB + fcsv_pkg::BYTE_BITS'(k);
   endfunction

   function automatic void push_number(longint value);
      if (value > VALUE_MAX) value = VALUE_MAX;
      if (value < VALUE_MIN) value = VALUE_MIN;
      if (value < 0) begin
         push_byte(CHAR_MINUS, 1'b0);
         push_text($sformatf("%0d", -value), 1'b0);
      end else begin
         if ($urandom_range(0, 3) == 0) push_byte(CHAR_PLUS, 1'b0);
         push_text($sformatf("%0d", value), 1'b0);
      end
   endfunction

   function automatic void push_field(int slot);
      longint value;
      int     span;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) push_byte(space_byte(), 1'b0);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            span  = (sb.jump_limit == 0) ? 3 : int'(sb.jump_limit);
            value = sb.previous_triple[slot] + longint'($urandom_range(0, 2 * span))
                  - longint'(span);
            push_number(value);
         end
         4, 5: begin
            value = longint'($urandom_range(0, 999));
            if ($urandom_range(0, 1) == 1) value = -value;
            push_number(value);
         end
         6: begin
            if ($urandom_range(0, 1) == 1) push_byte(CHAR_MINUS, 1'b0);
            push_byte(CHAR_ZERO + fcsv_pkg::BYTE_BITS'($urandom_range(1, 9)), 1'b0);
            repeat ($urandom_range(9, 12))
               push_byte(CHAR_ZERO + fcsv_pkg::BYTE_BITS'($urandom_range(0, 9)), 1'b0);
         end
         7: push_number(longint'($signed($urandom())));
         8: begin
            if ($urandom_range(0, 1) == 1)
               push_byte(($urandom_range(0, 1) == 1) ? CHAR_PLUS : CHAR_MINUS, 1'b0);
            repeat ($urandom_range(0, 2)) push_byte(junk_byte(), 1'b0);
         end
         default: begin
            push_number(longint'($urandom_range(0, 99)));
            push_byte(junk_byte(), 1'b0);
            push_number(longint'($urandom_range(0, 99)));
         end
      endcase
   endfunction

   function automatic void build_frame();
      int first_index;
      int field_count;
      int cut_at;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_byte(outside_byte(), 1'b0);
      first_index = frame_bytes.size();
      push_byte(sb.header_code, 1'b0);
      if ($urandom_range(0, 11) != 0) begin
         field_count = $urandom_range(1, 4);
         for (int k = 0; k < field_count; k++) begin
            if (k > 0) push_byte(sb.separator_code, 1'b0);
            push_field((k > 2) ? 2 : k);
         end
      end
      if ($urandom_range(0, 19) != 0) push_byte(sb.tail_code, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 11) == 0) begin
         cut_at = $urandom_range(first_index, frame_bytes.size() - 1);
         frame_bytes[cut_at].last_of_buffer = 1'b1;
      end
   endfunction

   function automatic void build_segment();
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 6))
            push_byte(fcsv_pkg::BYTE_BITS'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      else
         build_frame();
   endfunction

   task automatic send_byte(rx_item_type it, bit steady);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.rx_byte    = it.value;
      req_bus.buffer_end = it.last_of_buffer;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      sb.absorb_byte(it.value, it.last_of_buffer);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_queued();
      bit          steady;
      rx_item_type it;
      steady = ($urandom_range(0, 3) == 0);
      while (frame_bytes.size() != 0) begin
         it = frame_bytes.pop_front();
         send_byte(it, steady);
      end
   endtask

   task automatic settle();
      req_bus.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(fcsv_pkg::csr_index_type idx,
                                 logic [fcsv_pkg::CSR_DATA_BITS-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.set_register(idx, data);
   endtask

   task automatic apply_setting(logic [fcsv_pkg::BYTE_BITS-1:0] header_code,
                                logic [fcsv_pkg::BYTE_BITS-1:0] tail_code,
                                logic [fcsv_pkg::BYTE_BITS-1:0] separator_code,
                                logic [fcsv_pkg::LIMIT_BITS-1:0] limit);
      write_register(fcsv_pkg::CSR_HEADER, fcsv_pkg::CSR_DATA_BITS'(header_code));
      write_register(fcsv_pkg::CSR_TAIL, fcsv_pkg::CSR_DATA_BITS'(tail_code));
      write_register(fcsv_pkg::CSR_SEPARATOR, fcsv_pkg::CSR_DATA_BITS'(separator_code));
      write_register(fcsv_pkg::CSR_JUMP_LIMIT, fcsv_pkg::CSR_DATA_BITS'(limit));
      settings_applied++;
   endtask

   // receiver side with random back-pressure and one long hold-off on request
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_count < hold_requests) begin
            rsp_bus.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_count++;
         end
         rsp_bus.ready = 1'b1;
         repeat ($urandom_range(1, 40)) @(negedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      triple_type seen;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen.first     = rsp_bus.value_first;
         seen.second    = rsp_bus.value_second;
         seen.third     = rsp_bus.value_third;
         seen.plausible = rsp_bus.plausible;
         sb.check_triple(seen);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: no transaction for %0d cycles", quiet_cycles);
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      int phase_start;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.rx_byte    = '0;
      req_bus.buffer_end = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = fcsv_pkg::CSR_HEADER;
      csr_write_data     = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // empty frame, three fields with two of them signed, negative saturation on a buffer end
      push_text("@?", 1'b0);
      push_text("@1,-2,+3?", 1'b0);
      push_text("@ -99999999999?", 1'b1);
      send_queued();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase > 0) begin
            settle();
            case (phase)
               1: apply_setting(8'h00, 8'hff, 8'h3b, 16'h0000);
               2: apply_setting(8'hff, 8'h00, CHAR_SPACE, 16'hffff);
               3: apply_setting(8'h23, 8'h2a, CHAR_MINUS, 16'd1);
               4: apply_setting(8'h5b, 8'h5d, 8'h35, 16'd1000);
               5: apply_setting(8'h3c, 8'h3e, CHAR_PLUS, 16'd50000);
               default: apply_setting(fcsv_pkg::HEADER_RESET, fcsv_pkg::TAIL_RESET,
                                      fcsv_pkg::SEPARATOR_RESET, fcsv_pkg::LIMIT_RESET);
            endcase
         end
         if (phase == 1 || phase == 4) hold_requests++;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < ITEMS_PER_PHASE) begin
            build_segment();
            send_queued();
         end
      end

      settle();
      $display("tb_top: %0d bytes sent, %0d results checked over %0d register settings",
               bytes_sent, sb.checked_count, settings_applied + 1);
      $display("tb_top: %0d plausible, %0d implausible, %0d saturated fields, %0d hold-offs",
               sb.plausible_count, sb.checked_count - sb.plausible_count,
               sb.saturated_count, hold_count);
      if (sb.error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
